// ----- rtl/qmj_pkg.sv -----
// ----------------------------------------------------------------------------
// qmj_pkg
// Shared types and constants for the quintic minimum-jerk coefficient solver.
// ----------------------------------------------------------------------------
package qmj_pkg;

   localparam int CoefW  = 48;   // Q15.32 coefficient width
   localparam int QBits  = 49;   // quotient bits kept before rounding
   localparam int MagW   = 80;   // magnitude of a numerator
   localparam int DivW   = 100;  // divisor width, T^5 in Q.80
   localparam int DivN   = 49;   // restoring division steps, one per stage

   localparam logic [QBits-1:0] RNegLimit = {1'b1, {(QBits-1){1'b0}}} >> 1;
   localparam logic [QBits-1:0] RPosLimit = RNegLimit - QBits'(1);
   localparam logic [CoefW-1:0] CoefMax   = {1'b0, {(CoefW-1){1'b1}}};
   localparam logic [CoefW-1:0] CoefMin   = {1'b1, {(CoefW-1){1'b0}}};

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_ZERO = 2'd1,
      STATUS_SAT  = 2'd2
   } status_type;

   // fields that ride along unchanged to the output
   typedef struct packed {
      logic [CoefW-1:0] c0;
      logic [CoefW-1:0] c1;
      logic [CoefW-1:0] c2;
      logic             zero;
   } pass_type;

   // one divider lane: partial remainder plus shared numerator / quotient shifter
   typedef struct packed {
      logic [DivW-1:0]  d;
      logic [DivW-1:0]  rem;
      logic [QBits-1:0] lq;
      logic             neg;
      logic             ovf;
   } lane_type;

   typedef struct packed {
      pass_type         p;
      lane_type [2:0]   ln;
   } div_type;

   typedef struct packed {
      logic [CoefW-1:0] val;
      logic             sat;
   } round_type;

endpackage

// ----- rtl/quintic_min_jerk_coefficients_core.sv -----
// ----------------------------------------------------------------------------
// quintic_min_jerk_coefficients_core
// Pipelined solver for the six minimum-jerk quintic coefficients.
// ----------------------------------------------------------------------------
// Usage: a transaction on the req_ channel carries the start state, the end
// state (Q15.16) and the duration T (unsigned Q4.16). Each transaction yields
// exactly one transaction on the rsp_ channel with coef0..coef5 in Q15.32 and
// a status code (ok, zero duration, saturated), in input order.
// From acceptance to rsp_valid a transaction passes five arithmetic stages
// (differences, products with T, numerators, sign and magnitude), one divider
// set-up stage, 49 restoring division stages and the rounding/output register.
// Throughput is one transaction per cycle unless the receiver stalls; the
// three dividers run side by side, one quotient bit per stage each.
// Every stage holds its own valid bit and moves only when the stage after it
// is empty or moving, so when the receiver stalls, bubbles close up and
// req_ready stays high until the pipeline is actually full.
// A synchronous reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module quintic_min_jerk_coefficients_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_start_pos,
   input  logic signed [31:0] req_start_vel,
   input  logic signed [31:0] req_start_acc,
   input  logic signed [31:0] req_end_pos,
   input  logic signed [31:0] req_end_vel,
   input  logic signed [31:0] req_end_acc,
   input  logic [19:0]        req_duration,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [47:0] rsp_coef0,
   output logic signed [47:0] rsp_coef1,
   output logic signed [47:0] rsp_coef2,
   output logic signed [47:0] rsp_coef3,
   output logic signed [47:0] rsp_coef4,
   output logic signed [47:0] rsp_coef5,
   output logic [1:0]         rsp_status
);

   localparam int DivN = qmj_pkg::DivN;

   // stage valids and enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, vo_ff;
   logic [DivN:0] dv_ff;
   logic en1, en2, en3, en4, en5, eno;
   logic [DivN:0] en_d;

   assign eno = !vo_ff || rsp_ready;
   assign en_d[DivN] = !dv_ff[DivN] || eno;
   for (genvar k = 0; k < DivN; k++) begin : g_en
      assign en_d[k] = !dv_ff[k] || en_d[k+1];
   end
   assign en5 = !v5_ff || en_d[0];
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (eno) vo_ff <= dv_ff[DivN];
      end
   end

   // stage 1: differences and first products with T
   logic signed [32:0] s1_dp_ff, s1_dv_ff, s1_da_ff;
   logic signed [52:0] s1_vit_ff, s1_ait_ff;
   logic [39:0]        s1_t2_ff;
   logic [19:0]        s1_t_ff;
   qmj_pkg::pass_type  s1_p_ff, s1_p_in;
   logic signed [20:0] req_ts;

   assign req_ts = $signed({1'b0, req_duration});

   always_comb begin
      s1_p_in.c0   = {req_start_pos, 16'b0};
      s1_p_in.c1   = {req_start_vel, 16'b0};
      s1_p_in.c2   = {req_start_acc[31], req_start_acc, 15'b0};
      s1_p_in.zero = (req_duration == 20'd0);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_dp_ff  <= 33'(req_end_pos) - 33'(req_start_pos);
         s1_dv_ff  <= 33'(req_end_vel) - 33'(req_start_vel);
         s1_da_ff  <= 33'(req_end_acc) - 33'(req_start_acc);
         s1_vit_ff <= 53'(req_start_vel) * 53'(req_ts);
         s1_ait_ff <= 53'(req_start_acc) * 53'(req_ts);
         s1_t2_ff  <= 40'(req_duration) * 40'(req_duration);
         s1_t_ff   <= req_duration;
         s1_p_ff   <= s1_p_in;
      end
   end

   // stage 2
   logic signed [73:0] s2_ait2_ff;
   logic signed [53:0] s2_vv_ff, s2_at_ff;
   logic signed [70:0] s2_hp_ff;
   logic [59:0]        s2_t3_ff;
   logic [19:0]        s2_t_ff;
   qmj_pkg::pass_type  s2_p_ff;
   logic signed [20:0] s1_ts;

   assign s1_ts = $signed({1'b0, s1_t_ff});

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_ait2_ff <= 74'(s1_ait_ff) * 74'(s1_ts);
         s2_vv_ff   <= (54'(s1_dv_ff) <<< 16) - 54'(s1_ait_ff);
         s2_at_ff   <= 54'(s1_da_ff) * 54'(s1_ts);
         s2_hp_ff   <= (71'(s1_dp_ff) <<< 33) - (71'(s1_vit_ff) <<< 17);
         s2_t3_ff   <= 60'(s1_t2_ff) * 60'(s1_t_ff);
         s2_t_ff    <= s1_t_ff;
         s2_p_ff    <= s1_p_ff;
      end
   end

   // stage 3: hh = 2 h s^3, vt, a T^2
   logic signed [74:0] s3_hh_ff, s3_vt_ff, s3_at2_ff;
   logic [59:0]        s3_t3_ff;
   logic [79:0]        s3_t4_ff;
   logic [19:0]        s3_t_ff;
   qmj_pkg::pass_type  s3_p_ff;
   logic signed [20:0] s2_ts;

   assign s2_ts = $signed({1'b0, s2_t_ff});

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_hh_ff  <= 75'(s2_hp_ff) - 75'(s2_ait2_ff);
         s3_vt_ff  <= 75'(s2_vv_ff) * 75'(s2_ts);
         s3_at2_ff <= 75'(s2_at_ff) * 75'(s2_ts);
         s3_t4_ff  <= 80'(s2_t3_ff) * 80'(s2_t_ff);
         s3_t3_ff  <= s2_t3_ff;
         s3_t_ff   <= s2_t_ff;
         s3_p_ff   <= s2_p_ff;
      end
   end

   // stage 4: numerators of coef3..coef5
   logic signed [81:0] hh, vt, at2;
   logic signed [81:0] s4_m_ff [3];
   logic [59:0]        s4_t3_ff;
   logic [79:0]        s4_t4_ff;
   logic [59:0]        s4_t5lo_ff, s4_t5hi_ff;
   qmj_pkg::pass_type  s4_p_ff;

   assign hh  = 82'(s3_hh_ff);
   assign vt  = 82'(s3_vt_ff);
   assign at2 = 82'(s3_at2_ff);

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_m_ff[0] <= (hh <<< 3) + (hh <<< 1) - (vt <<< 3) + at2;
         s4_m_ff[1] <= (vt <<< 4) - (vt <<< 1) - (hh <<< 4) + hh - (at2 <<< 1);
         s4_m_ff[2] <= (hh <<< 2) + (hh <<< 1) - (vt <<< 2) - (vt <<< 1) + at2;
         // T^5 as two half-width products, summed in the next stage
         s4_t5lo_ff <= 60'(s3_t4_ff[39:0]) * 60'(s3_t_ff);
         s4_t5hi_ff <= 60'(s3_t4_ff[79:40]) * 60'(s3_t_ff);
         s4_t4_ff   <= s3_t4_ff;
         s4_t3_ff   <= s3_t3_ff;
         s4_p_ff    <= s3_p_ff;
      end
   end

   // stage 5: sign and magnitude
   logic [qmj_pkg::MagW-1:0] s5_mag_ff [3];
   logic [qmj_pkg::DivW-1:0] s5_d_ff [3];
   logic [2:0]               s5_neg_ff;
   qmj_pkg::pass_type        s5_p_ff;

   always_ff @(posedge clock) begin
      if (en5) begin
         for (int j = 0; j < 3; j++) begin
            s5_neg_ff[j] <= s4_m_ff[j][81];
            s5_mag_ff[j] <= s4_m_ff[j][81] ? qmj_pkg::MagW'(-s4_m_ff[j])
                                           : qmj_pkg::MagW'(s4_m_ff[j]);
         end
         s5_d_ff[0] <= qmj_pkg::DivW'(s4_t3_ff);
         s5_d_ff[1] <= qmj_pkg::DivW'(s4_t4_ff);
         s5_d_ff[2] <= (qmj_pkg::DivW'(s4_t5hi_ff) << 40) + qmj_pkg::DivW'(s4_t5lo_ff);
         s5_p_ff    <= s4_p_ff;
      end
   end

   // stage 6: divider set-up, numerator is mag << (32, 48, 64)
   qmj_pkg::div_type divs_ff [DivN+1];
   qmj_pkg::div_type d0_in;
   logic [qmj_pkg::DivW:0] hi [3];

   always_comb begin
      hi[0] = (qmj_pkg::DivW+1)'(s5_mag_ff[0] >> 17);
      hi[1] = (qmj_pkg::DivW+1)'(s5_mag_ff[1] >> 1);
      hi[2] = (qmj_pkg::DivW+1)'(s5_mag_ff[2]) << 15;
      d0_in.p = s5_p_ff;
      for (int j = 0; j < 3; j++) begin
         d0_in.ln[j].d   = s5_d_ff[j];
         d0_in.ln[j].rem = hi[j][qmj_pkg::DivW-1:0];
         d0_in.ln[j].neg = s5_neg_ff[j];
         // quotient would not fit the kept bits: saturates for sure
         d0_in.ln[j].ovf = (hi[j] >= {1'b0, s5_d_ff[j]});
      end
      d0_in.ln[0].lq = {s5_mag_ff[0][16:0], 32'b0};
      d0_in.ln[1].lq = {s5_mag_ff[1][0], 48'b0};
      d0_in.ln[2].lq = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en_d[0]) begin
         dv_ff[0] <= v5_ff;
      end
      if (en_d[0]) divs_ff[0] <= d0_in;
   end

   // restoring division, one quotient bit per stage per lane
   function automatic qmj_pkg::div_type div_step(input qmj_pkg::div_type x);
      qmj_pkg::div_type       y;
      logic [qmj_pkg::DivW:0] r2;
      logic                   ge;
      y = x;
      for (int j = 0; j < 3; j++) begin
         r2 = {x.ln[j].rem, x.ln[j].lq[qmj_pkg::QBits-1]};
         ge = (r2 >= {1'b0, x.ln[j].d});
         if (ge) begin
            r2 = r2 - {1'b0, x.ln[j].d};
         end
         y.ln[j].rem = r2[qmj_pkg::DivW-1:0];
         y.ln[j].lq  = {x.ln[j].lq[qmj_pkg::QBits-2:0], ge};
      end
      return y;
   endfunction

   for (genvar k = 1; k <= DivN; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else if (en_d[k]) begin
            dv_ff[k] <= dv_ff[k-1];
         end
         if (en_d[k]) divs_ff[k] <= div_step(divs_ff[k-1]);
      end
   end

   // rounding, ties away from zero, and saturation
   function automatic qmj_pkg::round_type round_lane(input qmj_pkg::lane_type l);
      qmj_pkg::round_type     o;
      logic [qmj_pkg::QBits:0] s;
      logic [qmj_pkg::QBits-1:0] r;
      s = {1'b0, l.lq} + (qmj_pkg::QBits+1)'(1);
      r = s[qmj_pkg::QBits:1];
      o.sat = l.ovf || (l.neg ? (r > qmj_pkg::RNegLimit) : (r > qmj_pkg::RPosLimit));
      if (o.sat) begin
         o.val = l.neg ? qmj_pkg::CoefMin : qmj_pkg::CoefMax;
      end else begin
         o.val = l.neg ? -r[qmj_pkg::CoefW-1:0] : r[qmj_pkg::CoefW-1:0];
      end
      return o;
   endfunction

   qmj_pkg::round_type rnd [3];
   qmj_pkg::div_type   dl;
   qmj_pkg::status_type status_in, status_ff;
   logic [47:0] c0_ff, c1_ff, c2_ff, c3_ff, c4_ff, c5_ff;

   assign dl = divs_ff[DivN];

   always_comb begin
      for (int j = 0; j < 3; j++) rnd[j] = round_lane(dl.ln[j]);
      if (dl.p.zero) begin
         status_in = qmj_pkg::STATUS_ZERO;
      end else if (rnd[0].sat || rnd[1].sat || rnd[2].sat) begin
         status_in = qmj_pkg::STATUS_SAT;
      end else begin
         status_in = qmj_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (eno) begin
         c0_ff     <= dl.p.c0;
         c1_ff     <= dl.p.c1;
         c2_ff     <= dl.p.c2;
         c3_ff     <= dl.p.zero ? '0 : rnd[0].val;
         c4_ff     <= dl.p.zero ? '0 : rnd[1].val;
         c5_ff     <= dl.p.zero ? '0 : rnd[2].val;
         status_ff <= status_in;
      end
   end

   assign rsp_valid  = vo_ff;
   assign rsp_coef0  = c0_ff;
   assign rsp_coef1  = c1_ff;
   assign rsp_coef2  = c2_ff;
   assign rsp_coef3  = c3_ff;
   assign rsp_coef4  = c4_ff;
   assign rsp_coef5  = c5_ff;
   assign rsp_status = status_ff;

`ifndef SYNTHESIS
   a_zero_clears : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status_ff == qmj_pkg::STATUS_ZERO |->
         c3_ff == '0 && c4_ff == '0 && c5_ff == '0)
      else $error("zero duration result with nonzero coefficients");

   a_enter : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted transaction did not enter the pipeline");

   a_div_hold : assert property (@(posedge clock) disable iff (reset)
      dv_ff[DivN] && !en_d[DivN] |=>
         dv_ff[DivN] && $stable(divs_ff[DivN].ln[0].lq))
      else $error("stalled divider stage lost or changed its transaction");

   a_sat_status : assert property (@(posedge clock) disable iff (reset)
      dv_ff[DivN] && eno && !dl.p.zero && rnd[2].sat |=> status_ff == qmj_pkg::STATUS_SAT)
      else $error("saturation not reported in status");
`endif

endmodule
